@@ sv/iira_pkg.sv @@
// ---------------------------------------------------------------------------
// iira_pkg
// Shared codes and types for the indexed insert/remove list engine.
// ---------------------------------------------------------------------------
`default_nettype none

package iira_pkg;

	localparam int unsigned OP_W     = 3;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned WORD_W   = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
	localparam logic [OP_W-1:0] OP_POP     = 3'd1;
	localparam logic [OP_W-1:0] OP_INS_AT  = 3'd2;
	localparam logic [OP_W-1:0] OP_REM_AT  = 3'd3;
	localparam logic [OP_W-1:0] OP_INS_MID = 3'd4;
	localparam logic [OP_W-1:0] OP_REM_MID = 3'd5;
	localparam logic [OP_W-1:0] OP_READ_AT = 3'd6;

	localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BAD  = 2'd2;

	typedef logic signed [WORD_W-1:0] word_t;

	typedef struct packed {
		logic ins;
		logic rem;
	} cmd_t;

endpackage

`default_nettype wire

@@ sv/iira_cell.sv @@
// ---------------------------------------------------------------------------
// iira_cell
// One list entry: holds, loads the new word, or takes a neighbour's entry.
// ---------------------------------------------------------------------------
`default_nettype none

module iira_cell #(
	parameter int unsigned AW  = 4,
	parameter int unsigned IDX = 0
) (
	input  wire                     clk,
	input  wire iira_pkg::cmd_t     cmd,
	input  wire [AW-1:0]            at,
	input  wire iira_pkg::word_t    new_word,
	input  wire iira_pkg::word_t    left,
	input  wire iira_pkg::word_t    right,
	output iira_pkg::word_t         data
);

	localparam logic [AW-1:0] MY_IDX = AW'(IDX);

	iira_pkg::word_t data_q;

	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			if (at == MY_IDX)
				data_q <= new_word;
			else if (MY_IDX > at)
				data_q <= left;
		end else if (cmd.rem) begin
			if (MY_IDX >= at)
				data_q <= right;
		end
	end

	assign data = data_q;

endmodule

`default_nettype wire

@@ sv/indexed_insert_remove_array_unit.sv @@
// ---------------------------------------------------------------------------
// indexed_insert_remove_array_unit
// Ordered list of signed words held in a chain of cells, with indexed
// insert and remove.
// ---------------------------------------------------------------------------
// One operation per clock: busy stays low, start is taken every cycle, and
// the result beat appears on done in the cycle after its start, with no way
// to hold it off. Every entry at or beyond the index moves to its neighbour
// in that same cycle, so the index does not change what an insert or remove
// costs. Count wraps in five bits when DEPTH exceeds 31.
`default_nettype none

module indexed_insert_remove_array_unit #(
	parameter int unsigned DEPTH = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire [iira_pkg::OP_W-1:0]             op,
	input  wire [iira_pkg::POS_W-1:0]            position,
	input  wire signed [iira_pkg::WORD_W-1:0]    word,
	output logic                                 done,
	output logic [iira_pkg::STATUS_W-1:0]        status,
	output logic signed [iira_pkg::WORD_W-1:0]   read_word,
	output logic [iira_pkg::COUNT_W-1:0]         count
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH + 1);
	localparam int unsigned CW = (FW > iira_pkg::POS_W) ? FW : iira_pkg::POS_W;
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

	logic [FW-1:0]                  fill_q;
	logic [FW-1:0]                  fill_d;
	logic                           done_q;
	logic [iira_pkg::STATUS_W-1:0]  status_q;
	iira_pkg::word_t                read_q;
	logic [iira_pkg::COUNT_W-1:0]   count_q;

	iira_pkg::word_t                cell_data [DEPTH];
	iira_pkg::cmd_t                 cmd;
	logic [AW-1:0]                  at;

	logic [CW-1:0]                  pos_c;
	logic [CW-1:0]                  fill_c;
	logic [CW-1:0]                  mid_c;
	logic [CW-1:0]                  ins_idx;
	logic [CW-1:0]                  rem_idx;
	logic [CW-1:0]                  fill_next_c;
	logic [iira_pkg::STATUS_W-1:0]  status_d;
	iira_pkg::word_t                read_d;
	logic                           is_ins;
	logic                           is_rem;

	assign busy   = 1'b0;
	assign pos_c  = CW'(position);
	assign fill_c = CW'(fill_q);
	assign mid_c  = fill_c >> 1;

	always_comb begin
		is_ins   = 1'b0;
		is_rem   = 1'b0;
		ins_idx  = fill_c;
		rem_idx  = pos_c;
		status_d = iira_pkg::ST_DONE;
		read_d   = '0;
		fill_d   = fill_q;
		cmd      = '0;
		case (op)
			iira_pkg::OP_PUSH: begin
				is_ins  = 1'b1;
				ins_idx = fill_c;
			end
			iira_pkg::OP_INS_AT: begin
				is_ins  = 1'b1;
				ins_idx = pos_c;
			end
			iira_pkg::OP_INS_MID: begin
				is_ins  = 1'b1;
				ins_idx = mid_c;
			end
			iira_pkg::OP_REM_AT: begin
				is_rem  = 1'b1;
				rem_idx = pos_c;
			end
			iira_pkg::OP_REM_MID: begin
				is_rem  = 1'b1;
				rem_idx = mid_c;
			end
			iira_pkg::OP_POP: begin
				if (fill_q == '0)
					status_d = iira_pkg::ST_BAD;
				else
					fill_d = fill_q - FW'(1);
			end
			iira_pkg::OP_READ_AT: begin
				if (pos_c >= fill_c)
					status_d = iira_pkg::ST_BAD;
				else
					read_d = cell_data[pos_c[AW-1:0]];
			end
			default: begin
				status_d = iira_pkg::ST_BAD;
			end
		endcase
		if (is_ins) begin
			if (ins_idx > fill_c) begin
				status_d = iira_pkg::ST_BAD;
			end else if (fill_c == DEPTH_C) begin
				status_d = iira_pkg::ST_FULL;
			end else begin
				cmd.ins = start;
				fill_d  = fill_q + FW'(1);
			end
		end
		if (is_rem) begin
			if (rem_idx >= fill_c) begin
				status_d = iira_pkg::ST_BAD;
			end else begin
				cmd.rem = start;
				fill_d  = fill_q - FW'(1);
			end
		end
		at          = is_ins ? ins_idx[AW-1:0] : rem_idx[AW-1:0];
		fill_next_c = CW'(fill_d);
	end

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		iira_pkg::word_t left_w;
		iira_pkg::word_t right_w;

		if (i == 0) begin : g_first
			assign left_w = cell_data[0];
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		iira_cell #(
			.AW  (AW),
			.IDX (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.at       (at),
			.new_word (word),
			.left     (left_w),
			.right    (right_w),
			.data     (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= start;
			if (start)
				fill_q <= fill_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			status_q <= status_d;
			read_q   <= read_d;
			count_q  <= fill_next_c[iira_pkg::COUNT_W-1:0];
		end
	end

	assign done      = done_q;
	assign status    = status_q;
	assign read_word = read_q;
	assign count     = count_q;

endmodule

`default_nettype wire
